/* rtl/stpc_pkg.sv */
package stpc_pkg;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_OSCAN,
		ST_PSCAN,
		ST_UPD,
		ST_RESP
	} stpc_state_t;

	// Item kinds carried on the input side channel.
	localparam logic [1:0] MODE_CHECK  = 2'd0;
	localparam logic [1:0] MODE_ACCEPT = 2'd1;
	localparam logic [1:0] MODE_CANCEL = 2'd2;
	localparam logic [1:0] MODE_EXEC   = 2'd3;

	// Result status codes.
	localparam logic [1:0] STAT_DONE     = 2'd0;
	localparam logic [1:0] STAT_NOTFOUND = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;

	localparam int KEY_W = 62;

	// One entry of the order table.
	typedef struct packed {
		logic             valid;
		logic [31:0]      id;
		logic             side;
		logic [KEY_W-1:0] key;
		logic [31:0]      rem;
	} order_ent_t;

	localparam int ORDER_W = $bits(order_ent_t);

endpackage

/* rtl/stpc_ram.sv */
module stpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/self_trade_prevention_checker_unit.sv */
// An item passes through a scan of the order table (skipped for a check) and a scan of the
// position table (skipped when a cancel or execute finds no order), then update and response.
// Items are handled one at a time; the linear scans through the single-port table
// reads and the shared comparator limit how fast they go.
// Reset: arst_n clears control state, then a clearing pass over max(ORDER_SLOTS,
// POSITION_SLOTS) addresses marks all table entries free before the first item is taken.
module self_trade_prevention_checker_unit
	import stpc_pkg::*;
#(
	parameter int ORDER_SLOTS    = 1024,
	parameter int POSITION_SLOTS = 1024,
	parameter int OPEN_SUM_BITS  = 40
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// order_id[31:0], shareholder_id[71:32], market[73:72], security_id[93:74],
	// side[94], quantity[126:95], zero[127]
	input  logic [127:0] s_axis_tdata,
	// mode[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// cross_flag[0], status[2:1], zero[7:3]
	output logic [7:0]   m_axis_tdata
);

	localparam int OAW  = $clog2(ORDER_SLOTS);
	localparam int PAW  = $clog2(POSITION_SLOTS);
	localparam int MAXD = (ORDER_SLOTS > POSITION_SLOTS) ? ORDER_SLOTS : POSITION_SLOTS;
	localparam int CW   = $clog2(MAXD) + 1;
	localparam int SB   = OPEN_SUM_BITS;
	localparam int POS_W = 1 + KEY_W + 2 * SB;

	stpc_state_t state_q, state_d;

	// Latched item.
	logic [1:0]       mode_q;
	logic [31:0]      id_q;
	logic             side_q;
	logic [31:0]      qty_q;
	logic [KEY_W-1:0] key_in_q;
	logic [KEY_W-1:0] pkey_q;

	// Scan pipeline.
	logic [CW-1:0] scan_idx_q;
	logic [CW-1:0] idx_s1;
	logic          rvld_s1;
	logic [CW-1:0] clr_q;

	// Scan findings.
	logic             o_hit_q, o_free_q, p_hit_q, p_free_q;
	logic [OAW-1:0]   o_idx_q, o_fidx_q;
	logic [PAW-1:0]   p_idx_q, p_fidx_q;
	order_ent_t       o_ent_q;
	logic [SB-1:0]    p_buy_q, p_sell_q;

	// Output register.
	logic       m_valid_q;
	logic       cross_q;
	logic [1:0] status_q;

	// Memory ports.
	logic               o_we, p_we;
	logic [OAW-1:0]     o_waddr;
	logic [PAW-1:0]     p_waddr;
	logic [ORDER_W-1:0] o_wdata, o_rdata;
	logic [POS_W-1:0]   p_wdata, p_rdata;
	order_ent_t         o_rd, o_new;

	stpc_ram #(.WIDTH(ORDER_W), .DEPTH(ORDER_SLOTS)) u_order_ram (
		.clk   (clk),
		.we    (o_we),
		.waddr (o_waddr),
		.wdata (o_wdata),
		.raddr (scan_idx_q[OAW-1:0]),
		.rdata (o_rdata)
	);

	stpc_ram #(.WIDTH(POS_W), .DEPTH(POSITION_SLOTS)) u_pos_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (scan_idx_q[PAW-1:0]),
		.rdata (p_rdata)
	);

	assign o_rd = order_ent_t'(o_rdata);

	// Shared comparator: order id in the order scan, entry key in the position scan.
	logic             in_oscan;
	logic             ent_valid, ent_match, hit, last, scan_done, issue;
	logic [KEY_W-1:0] cmp_a, cmp_b;
	logic [CW-1:0]    limit;

	always_comb begin
		in_oscan  = (state_q == ST_OSCAN);
		ent_valid = in_oscan ? o_rd.valid : p_rdata[POS_W-1];
		cmp_a     = in_oscan ? {{(KEY_W-32){1'b0}}, o_rd.id} : p_rdata[POS_W-2 -: KEY_W];
		cmp_b     = in_oscan ? {{(KEY_W-32){1'b0}}, id_q} : pkey_q;
		ent_match = (cmp_a == cmp_b);
		limit     = in_oscan ? CW'(ORDER_SLOTS) : CW'(POSITION_SLOTS);
		hit       = rvld_s1 && ent_valid && ent_match;
		last      = rvld_s1 && (idx_s1 == limit - CW'(1));
		scan_done = hit || last;
		issue     = (state_q == ST_OSCAN || state_q == ST_PSCAN) && !scan_done &&
		            (scan_idx_q < limit);
	end

	// Update arithmetic on the captured entries.
	logic          upd_side, full;
	logic [31:0]   cut, rem_new;
	logic [SB-1:0] sum_old, amt, sum_new, new_buy, new_sell;
	logic [SB:0]   sum_add;
	logic          cross_d;

	always_comb begin
		upd_side = (mode_q == MODE_ACCEPT) ? side_q : o_ent_q.side;
		cut      = (mode_q == MODE_CANCEL || qty_q >= o_ent_q.rem) ? o_ent_q.rem : qty_q;
		rem_new  = o_ent_q.rem - cut;
		sum_old  = p_hit_q ? (upd_side ? p_sell_q : p_buy_q) : '0;
		amt      = SB'(cut);
		sum_add  = {1'b0, sum_old} + (SB + 1)'(qty_q);
		if (mode_q == MODE_ACCEPT) begin
			sum_new = sum_add[SB] ? '1 : sum_add[SB-1:0];
		end else begin
			sum_new = (sum_old >= amt) ? sum_old - amt : '0;
		end
		new_buy  = upd_side ? (p_hit_q ? p_buy_q : '0) : sum_new;
		new_sell = upd_side ? sum_new : (p_hit_q ? p_sell_q : '0);
		full     = (!o_hit_q && !o_free_q) || (!p_hit_q && qty_q != 32'd0 && !p_free_q);
		cross_d  = (mode_q == MODE_CHECK) && p_hit_q &&
		           ((side_q ? p_buy_q : p_sell_q) != '0);
	end

	// Memory write control.
	always_comb begin
		o_we    = 1'b0;
		p_we    = 1'b0;
		o_waddr = o_idx_q;
		p_waddr = p_idx_q;
		o_new   = '0;
		p_wdata = '0;
		if (state_q == ST_CLEAR) begin
			o_we    = (clr_q < CW'(ORDER_SLOTS));
			p_we    = (clr_q < CW'(POSITION_SLOTS));
			o_waddr = clr_q[OAW-1:0];
			p_waddr = clr_q[PAW-1:0];
		end else if (state_q == ST_UPD) begin
			unique case (mode_q)
				MODE_ACCEPT: begin
					o_we    = !full;
					p_we    = !full && (qty_q != 32'd0);
					o_waddr = o_hit_q ? o_idx_q : o_fidx_q;
					p_waddr = p_hit_q ? p_idx_q : p_fidx_q;
					o_new   = '{valid: 1'b1, id: id_q, side: side_q, key: key_in_q, rem: qty_q};
					p_wdata = {1'b1, key_in_q, new_buy, new_sell};
				end
				MODE_CANCEL, MODE_EXEC: begin
					o_we  = o_hit_q;
					p_we  = o_hit_q && p_hit_q;
					o_new = o_ent_q;
					if (mode_q == MODE_CANCEL || rem_new == 32'd0) begin
						o_new = '0;
					end else begin
						o_new.rem = rem_new;
					end
					p_wdata = {(new_buy != '0 || new_sell != '0), pkey_q, new_buy, new_sell};
				end
				default: begin
				end
			endcase
		end
		o_wdata = o_new;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == CW'(MAXD - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = (s_axis_tuser == MODE_CHECK) ? ST_PSCAN : ST_OSCAN;
				end
			end
			ST_OSCAN: begin
				if (scan_done) begin
					if (mode_q == MODE_ACCEPT || hit) state_d = ST_PSCAN;
					else state_d = ST_UPD;
				end
			end
			ST_PSCAN: if (scan_done) state_d = ST_UPD;
			ST_UPD:   state_d = ST_RESP;
			ST_RESP:  if (m_axis_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		m_axis_tvalid = m_valid_q;
		m_axis_tdata  = {5'd0, status_q, cross_q};
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			scan_idx_q <= '0;
			rvld_s1    <= 1'b0;
			m_valid_q  <= 1'b0;
			o_hit_q    <= 1'b0;
			o_free_q   <= 1'b0;
			p_hit_q    <= 1'b0;
			p_free_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + CW'(1);
			if (scan_done) begin
				scan_idx_q <= '0;
				rvld_s1    <= 1'b0;
			end else if (issue) begin
				scan_idx_q <= scan_idx_q + CW'(1);
				rvld_s1    <= 1'b1;
			end else begin
				rvld_s1 <= 1'b0;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				o_hit_q  <= 1'b0;
				o_free_q <= 1'b0;
				p_hit_q  <= 1'b0;
				p_free_q <= 1'b0;
			end
			if (state_q == ST_OSCAN && rvld_s1) begin
				if (hit) o_hit_q <= 1'b1;
				if (!ent_valid) o_free_q <= 1'b1;
			end
			if (state_q == ST_PSCAN && rvld_s1) begin
				if (hit) p_hit_q <= 1'b1;
				if (!ent_valid) p_free_q <= 1'b1;
			end
			if (state_q == ST_UPD) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (issue) idx_s1 <= scan_idx_q;
		if (s_axis_tvalid && s_axis_tready) begin
			mode_q   <= s_axis_tuser;
			id_q     <= s_axis_tdata[31:0];
			side_q   <= s_axis_tdata[94];
			qty_q    <= s_axis_tdata[126:95];
			key_in_q <= {s_axis_tdata[71:32], s_axis_tdata[73:72], s_axis_tdata[93:74]};
			pkey_q   <= {s_axis_tdata[71:32], s_axis_tdata[73:72], s_axis_tdata[93:74]};
		end
		if (state_q == ST_OSCAN && rvld_s1) begin
			if (hit) begin
				o_idx_q <= idx_s1[OAW-1:0];
				o_ent_q <= o_rd;
				// An accept searches its own key; cancel and execute use the stored one.
				if (mode_q != MODE_ACCEPT) pkey_q <= o_rd.key;
			end
			if (!ent_valid && !o_free_q) o_fidx_q <= idx_s1[OAW-1:0];
		end
		if (state_q == ST_PSCAN && rvld_s1) begin
			if (hit) begin
				p_idx_q  <= idx_s1[PAW-1:0];
				p_buy_q  <= p_rdata[2*SB-1:SB];
				p_sell_q <= p_rdata[SB-1:0];
			end
			if (!ent_valid && !p_free_q) p_fidx_q <= idx_s1[PAW-1:0];
		end
		if (state_q == ST_UPD) begin
			cross_q <= cross_d;
			if (mode_q == MODE_ACCEPT) status_q <= full ? STAT_FULL : STAT_DONE;
			else if (mode_q == MODE_CHECK || o_hit_q) status_q <= STAT_DONE;
			else status_q <= STAT_NOTFOUND;
		end
	end

	// The block takes no item while a result is pending.
	a_ready_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid) else $error("input ready while result pending");

	// An accepted item closes the input side.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input still ready after accept");

	// A cross trade is only reported with a done status.
	a_cross_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[2:1] == STAT_DONE))
		else $error("cross trade with non-done status");

	// Scan reads are only issued below the depth of the larger table.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (scan_idx_q < CW'(MAXD))) else $error("scan index out of range");

endmodule
